// ===== design/rls_pkg.sv =====
package rls_pkg;

  localparam int MAX_ROWS = 256;
  localparam int MAX_COLS = 256;

  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // Configuration registers are 9 bits wide; counters must also hold the
  // largest line length itself.
  localparam int CFG_W   = 9;
  localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int CNT_W   = (DIM_W > CFG_W) ? DIM_W : CFG_W;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_SMEAR = 2'd2;

  localparam int APB_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;
  localparam logic [REG_IDX_W-1:0] REG_GAP_THRESHOLD = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COL_COUNT     = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_DIRECTION     = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] row;
    logic [7:0] col;
    logic       pixel_in;
  } rls_cmd_t;

  typedef struct packed {
    logic pixel_out;
    logic smear_done;
  } rls_rsp_t;

  typedef struct packed {
    logic [CFG_W-1:0] gap_threshold;
    logic [CFG_W-1:0] row_count;
    logic [CFG_W-1:0] col_count;
    logic             smear_direction;
  } rls_cfg_t;

  typedef struct packed {
    logic              we;
    logic              wdata;
    logic [ADDR_W-1:0] addr;
  } rls_mem_req_t;

  typedef struct packed {
    logic     load;
    rls_rsp_t item;
  } rls_res_t;

  typedef struct packed {
    logic idle;
    logic filling;
  } rls_stat_t;

  function automatic logic [ADDR_W-1:0] pix_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    pix_addr = ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
  endfunction

endpackage

// ===== design/rls_step_unit.sv =====
module rls_step_unit import rls_pkg::*; (
  input  logic [CNT_W-1:0] operand,
  input  logic [CNT_W-1:0] limit,
  output logic [CNT_W-1:0] inc,
  output logic             last
);

  // Shared increment and end-of-range compare for every index of a pass.
  assign inc  = operand + CNT_W'(1);
  assign last = (inc == limit);

endmodule

// ===== design/rls_image_mem.sv =====
module rls_image_mem import rls_pkg::*; (
  input  logic         clk,
  input  rls_mem_req_t req,
  output logic         rdata
);

  logic mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

// ===== design/rls_walker.sv =====
module rls_walker import rls_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         take,
  input  rls_cmd_t     cmd,
  input  rls_cfg_t     cfg,
  input  logic         rdata,
  output rls_mem_req_t mem_req,
  output rls_res_t     res,
  output rls_stat_t    stat
);

  typedef enum logic [2:0] {
    IDLE, RD_WAIT, SC_ADDR, SC_EVAL, FILL, SC_STEP, NEXT_LINE, DONE
  } state_t;

  state_t state;
  logic [CNT_W-1:0] line;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] gap;
  logic             seen;
  logic             rd_inside;

  logic [CNT_W-1:0] rows, cols, lines, len;
  logic [CNT_W-1:0] unit_op, unit_lim, unit_inc;
  logic             unit_last;
  logic [CNT_W-1:0] idx;
  logic [ADDR_W-1:0] host_addr, walk_addr;
  logic             host_inside;
  logic             fill_now;

  rls_step_unit u_step (
    .operand (unit_op),
    .limit   (unit_lim),
    .inc     (unit_inc),
    .last    (unit_last)
  );

  always_comb begin
    rows = (CNT_W'(cfg.row_count) > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS)
                                                       : CNT_W'(cfg.row_count);
    cols = (CNT_W'(cfg.col_count) > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS)
                                                       : CNT_W'(cfg.col_count);
    lines = cfg.smear_direction ? cols : rows;
    len   = cfg.smear_direction ? rows : cols;
  end

  assign host_inside = (32'(cmd.row) < MAX_ROWS) && (32'(cmd.col) < MAX_COLS);
  assign host_addr   = pix_addr(ROW_W'(cmd.row), COL_W'(cmd.col));
  assign idx         = (state == FILL) ? k : pos;
  assign walk_addr   = cfg.smear_direction ? pix_addr(ROW_W'(idx), COL_W'(line))
                                           : pix_addr(ROW_W'(line), COL_W'(idx));

  // A black pixel closes a gap; a short enough gap behind it is blackened.
  assign fill_now = !rdata && seen && (gap != '0) && (gap <= CNT_W'(cfg.gap_threshold));

  always_comb begin
    unique case (state)
      NEXT_LINE: begin
        unit_op  = line;
        unit_lim = lines;
      end
      FILL: begin
        unit_op  = k;
        unit_lim = pos;
      end
      default: begin
        unit_op  = pos;
        unit_lim = len;
      end
    endcase
  end

  always_comb begin
    mem_req.addr  = (state == IDLE) ? host_addr : walk_addr;
    mem_req.we    = ((state == IDLE) && take && (cmd.opcode == OP_WRITE) && host_inside)
                    || (state == FILL);
    mem_req.wdata = (state == FILL) ? 1'b0 : cmd.pixel_in;

    res.load            = (state == RD_WAIT) || (state == DONE);
    res.item.pixel_out  = (state == RD_WAIT) && rd_inside && rdata;
    res.item.smear_done = (state == DONE);

    stat.idle    = (state == IDLE);
    stat.filling = (state == FILL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      line      <= '0;
      pos       <= '0;
      k         <= '0;
      gap       <= '0;
      seen      <= 1'b0;
      rd_inside <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (take) begin
            case (cmd.opcode)
              OP_READ: begin
                rd_inside <= host_inside;
                state     <= RD_WAIT;
              end
              OP_SMEAR: begin
                if ((lines == '0) || (len == '0)) begin
                  state <= DONE;
                end else begin
                  line  <= '0;
                  pos   <= '0;
                  gap   <= '0;
                  seen  <= 1'b0;
                  state <= SC_ADDR;
                end
              end
              default: begin
                // Writes go straight to the store; the unused code is dropped.
              end
            endcase
          end
        end
        RD_WAIT: begin
          state <= IDLE;
        end
        SC_ADDR: begin
          state <= SC_EVAL;
        end
        SC_EVAL: begin
          if (fill_now) begin
            k     <= pos - gap;
            gap   <= '0;
            state <= FILL;
          end else begin
            if (!rdata) begin
              gap  <= '0;
              seen <= 1'b1;
            end else if (seen) begin
              gap <= gap + CNT_W'(1);
            end
            if (unit_last) begin
              state <= NEXT_LINE;
            end else begin
              pos   <= unit_inc;
              state <= SC_ADDR;
            end
          end
        end
        FILL: begin
          k <= unit_inc;
          if (unit_last) begin
            state <= SC_STEP;
          end
        end
        SC_STEP: begin
          if (unit_last) begin
            state <= NEXT_LINE;
          end else begin
            pos   <= unit_inc;
            state <= SC_ADDR;
          end
        end
        NEXT_LINE: begin
          if (unit_last) begin
            state <= DONE;
          end else begin
            line  <= unit_inc;
            pos   <= '0;
            gap   <= '0;
            seen  <= 1'b0;
            state <= SC_ADDR;
          end
        end
        DONE: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/run_length_smear.sv =====
// Binary image store with run-length smoothing.
// Commands arrive on cmd (cmd_valid, cmd_stall, cmd) and results leave on
// rsp (rsp_valid, rsp_stall, rsp). A beat moves when valid is high and stall
// is low. A pixel write gives no result. A pixel read passes through
// the store's read register and then the output register. A smear walks
// the configured region line by line through one increment/compare unit and
// a single-port store: each pixel gets an address step and an evaluation
// step, each blackened pixel a fill write, each filled gap a step state and
// each line a line step; it then gives one done beat. cmd_stall stays high
// while a read or smear is in progress.
// The registers are set over the APB port (gap_threshold, row_count,
// col_count, smear_direction at byte addresses 0, 4, 8 and 12).
// Reset returns the registers to their defaults and the sequencer to idle;
// the image is undefined until written and is not cleared.
// While rsp_stall holds a waiting result, no new command is taken; one is
// taken in the cycle in which the waiting result leaves.
module run_length_smear import rls_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  rls_cmd_t              cmd,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rls_rsp_t              rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  rls_cfg_t     cfg;
  rls_mem_req_t mem_req;
  rls_res_t     res;
  rls_stat_t    stat;
  logic         rdata;
  logic         take;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gap_threshold   <= '0;
      cfg.row_count       <= CFG_W'(256);
      cfg.col_count       <= CFG_W'(256);
      cfg.smear_direction <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_GAP_THRESHOLD: cfg.gap_threshold   <= pwdata[CFG_W-1:0];
        REG_ROW_COUNT:     cfg.row_count       <= pwdata[CFG_W-1:0];
        REG_COL_COUNT:     cfg.col_count       <= pwdata[CFG_W-1:0];
        REG_DIRECTION:     cfg.smear_direction <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GAP_THRESHOLD: prdata = 32'(cfg.gap_threshold);
      REG_ROW_COUNT:     prdata = 32'(cfg.row_count);
      REG_COL_COUNT:     prdata = 32'(cfg.col_count);
      REG_DIRECTION:     prdata = 32'(cfg.smear_direction);
    endcase
  end

  assign cmd_stall = !stat.idle || (rsp_valid && rsp_stall);
  assign take      = cmd_valid && !cmd_stall;

  rls_walker u_walker (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .cmd     (cmd),
    .cfg     (cfg),
    .rdata   (rdata),
    .mem_req (mem_req),
    .res     (res),
    .stat    (stat)
  );

  rls_image_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res.load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      rsp <= res.item;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res.load |-> !(rsp_valid && rsp_stall))
    else $error("result loaded over a stalled beat");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    res.load |=> rsp_valid)
    else $error("loaded result not presented");

  a_fill_black: assert property (@(posedge clk) disable iff (rst)
    stat.filling |-> (mem_req.we && !mem_req.wdata))
    else $error("gap fill did not write black");

  a_done_black: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.smear_done) |-> !rsp.pixel_out)
    else $error("done beat carries a pixel");

endmodule

// ===== dv/tb_run_length_smear.sv =====
`timescale 1ns / 100ps

module tb_run_length_smear;
  import rls_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int NPIX = MAX_ROWS * MAX_COLS;
  localparam int ITEM_GOAL = 1750;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cmd_valid = 1'b0;
  logic                  cmd_stall;
  rls_cmd_t              cmd = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  rls_rsp_t              rsp;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  run_length_smear u_dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Image and register copy used to predict the block.
  bit       img_model [NPIX];
  int       cfg_thr = 0;
  int       cfg_rows = 256;
  int       cfg_cols = 256;
  int       cfg_dir = 0;
  rls_rsp_t answers_due [$];

  // Stimulus bookkeeping: which pixels have been written so far.
  bit       px_written [NPIX];
  int       known_px [$];
  rls_cmd_t cmd_backlog [$];
  int       items_made = 0;

  int       mismatches = 0;
  int       results_seen = 0;
  bit       cmd_moved = 1'b0;

  function automatic int px_of(int r, int c);
    return r * MAX_COLS + c;
  endfunction

  function automatic int line_px_of(int ln, int pos);
    return (cfg_dir != 0) ? px_of(pos, ln) : px_of(ln, pos);
  endfunction

  function automatic void report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", msg);
  endfunction

  function automatic int eff_rows();
    return (cfg_rows > MAX_ROWS) ? MAX_ROWS : cfg_rows;
  endfunction

  function automatic int eff_cols();
    return (cfg_cols > MAX_COLS) ? MAX_COLS : cfg_cols;
  endfunction

  // Run-length smoothing over every line of the configured region.
  function automatic void model_smear();
    int  lines;
    int  len;
    int  gap;
    bit  seen;
    lines = (cfg_dir != 0) ? eff_cols() : eff_rows();
    len   = (cfg_dir != 0) ? eff_rows() : eff_cols();
    for (int ln = 0; ln < lines; ln++) begin
      gap  = 0;
      seen = 1'b0;
      for (int pos = 0; pos < len; pos++) begin
        if (!img_model[line_px_of(ln, pos)]) begin
          if (seen && gap <= cfg_thr) begin
            for (int k = pos - gap; k < pos; k++) img_model[line_px_of(ln, k)] = 1'b0;
          end
          gap  = 0;
          seen = 1'b1;
        end else if (seen) begin
          gap++;
        end
      end
    end
  endfunction

  function automatic void predict_beat(rls_cmd_t c);
    rls_rsp_t ans;
    int       a;
    a = px_of(int'(c.row), int'(c.col));
    ans = '0;
    case (c.opcode)
      OP_WRITE: begin
        img_model[a] = c.pixel_in;
      end
      OP_READ: begin
        ans.pixel_out = img_model[a];
        answers_due.push_back(ans);
      end
      OP_SMEAR: begin
        model_smear();
        ans.smear_done = 1'b1;
        answers_due.push_back(ans);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic rls_cmd_t make_cmd(logic [1:0] op, int r, int c, bit p);
    rls_cmd_t x;
    x.opcode   = op;
    x.row      = r[7:0];
    x.col      = c[7:0];
    x.pixel_in = p;
    return x;
  endfunction

  function automatic void queue_write(int r, int c, bit p);
    int a;
    a = px_of(r, c);
    cmd_backlog.push_back(make_cmd(OP_WRITE, r, c, p));
    if (!px_written[a]) begin
      px_written[a] = 1'b1;
      known_px.push_back(a);
    end
    items_made++;
  endfunction

  function automatic void queue_read(int r, int c);
    cmd_backlog.push_back(make_cmd(OP_READ, r, c, 1'b0));
    items_made++;
  endfunction

  function automatic void queue_read_known();
    int a;
    a = known_px[$urandom_range(0, known_px.size() - 1)];
    queue_read(a / MAX_COLS, a % MAX_COLS);
  endfunction

  function automatic void queue_smear();
    cmd_backlog.push_back(make_cmd(OP_SMEAR, $urandom_range(0, 255), $urandom_range(0, 255),
                                   $urandom_range(0, 1) == 1));
    items_made++;
  endfunction

  function automatic void queue_region_read();
    if (eff_rows() == 0 || eff_cols() == 0) begin
      queue_read_known();
    end else begin
      queue_read($urandom_range(0, eff_rows() - 1), $urandom_range(0, eff_cols() - 1));
    end
  endfunction

  // Noise: unused opcodes, stray writes anywhere, reads of any written pixel.
  function automatic void queue_noise();
    case ($urandom_range(0, 2))
      0: cmd_backlog.push_back(make_cmd(OP_UNUSED, $urandom_range(0, 255),
                                        $urandom_range(0, 255), $urandom_range(0, 1) == 1));
      1: queue_write($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1) == 1);
      default: queue_read_known();
    endcase
  endfunction

  // Writes the whole region line by line as alternating runs whose lengths
  // cluster around the threshold, so both filled and kept gaps occur.
  function automatic void fill_region();
    bit line_px [MAX_DIM];
    int lines;
    int len;
    int pos;
    int run;
    bit color;
    lines = (cfg_dir != 0) ? eff_cols() : eff_rows();
    len   = (cfg_dir != 0) ? eff_rows() : eff_cols();
    for (int ln = 0; ln < lines; ln++) begin
      pos   = 0;
      color = $urandom_range(0, 1) == 1;
      while (pos < len) begin
        case ($urandom_range(0, 3))
          0: run = cfg_thr;
          1: run = cfg_thr + 1;
          default: run = $urandom_range(1, 3);
        endcase
        if (run < 1) run = 1;
        for (int k = 0; k < run && pos < len; k++) begin
          line_px[pos] = color;
          pos++;
        end
        color = !color;
      end
      for (int p = 0; p < len; p++) begin
        if (cfg_dir != 0) queue_write(p, ln, line_px[p]);
        else queue_write(ln, p, line_px[p]);
        if ($urandom_range(0, 11) == 0) queue_noise();
      end
    end
  endfunction

  task automatic apb_write(logic [REG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(logic [REG_IDX_W-1:0] idx, int want);
    logic [31:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== 32'(want))
      report_mismatch($sformatf("register %0d read expected %0d got %0d", idx, want, got));
  endtask

  task automatic set_region(int thr, int rows, int cols, int dir);
    apb_write(REG_GAP_THRESHOLD, thr);
    apb_write(REG_ROW_COUNT, rows);
    apb_write(REG_COL_COUNT, cols);
    apb_write(REG_DIRECTION, dir);
    cfg_thr  = thr;
    cfg_rows = rows;
    cfg_cols = cols;
    cfg_dir  = dir;
    apb_read(REG_GAP_THRESHOLD, thr);
    apb_read(REG_ROW_COUNT, rows);
    apb_read(REG_COL_COUNT, cols);
    apb_read(REG_DIRECTION, dir);
  endtask

  // Idle means every beat has gone in and every answer has come back; the
  // extra cycles let a trailing pixel write settle.
  task automatic wait_quiet();
    while (cmd_backlog.size() != 0 || cmd_valid || answers_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic run_phase(int thr, int rows, int cols, int dir);
    wait_quiet();
    set_region(thr, rows, cols, dir);
    fill_region();
    queue_smear();
    repeat ($urandom_range(4, 12)) queue_region_read();
    if ($urandom_range(0, 1) == 1) begin
      if (eff_rows() != 0 && eff_cols() != 0) begin
        repeat ($urandom_range(1, 6))
          queue_write($urandom_range(0, eff_rows() - 1), $urandom_range(0, eff_cols() - 1),
                      $urandom_range(0, 1) == 1);
      end
      queue_smear();
      repeat ($urandom_range(1, 5)) queue_region_read();
    end
    repeat ($urandom_range(0, 3)) queue_noise();
  endtask

  function automatic int pick_count();
    if ($urandom_range(0, 9) == 0) return 0;
    return $urandom_range(1, 12);
  endfunction

  function automatic int pick_thr();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 1;
      2: return 2;
      3: return $urandom_range(3, 8);
      4: return $urandom_range(0, 12);
      default: return $urandom_range(0, 511);
    endcase
  endfunction

  // Command side: beats accepted at the rising edge feed the predictor.
  always @(posedge clk) begin
    if (!rst && cmd_valid && !cmd_stall) begin
      predict_beat(cmd);
      cmd_moved = 1'b1;
    end
  end

  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    logic [31:0] raw;
    raw = $urandom;
    if (!rst && (!cmd_valid || cmd_moved)) begin
      if (gap_left > 0) begin
        gap_left--;
        cmd_valid <= 1'b0;
        cmd       <= raw[$bits(rls_cmd_t)-1:0];
      end else if (cmd_backlog.size() != 0) begin
        cmd       <= cmd_backlog.pop_front();
        cmd_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                    : $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        cmd_valid <= 1'b0;
        cmd       <= raw[$bits(rls_cmd_t)-1:0];
      end
    end
    cmd_moved = 1'b0;
  end

  // Result side: compare each beat with the oldest answer owed.
  always @(posedge clk) begin
    rls_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      results_seen++;
      if (answers_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result pixel_out=%0b smear_done=%0b",
                                  rsp.pixel_out, rsp.smear_done));
      end else begin
        want = answers_due.pop_front();
        if (rsp.pixel_out !== want.pixel_out)
          report_mismatch($sformatf("result %0d pixel_out expected %0b got %0b",
                                    results_seen, want.pixel_out, rsp.pixel_out));
        if (rsp.smear_done !== want.smear_done)
          report_mismatch($sformatf("result %0d smear_done expected %0b got %0b",
                                    results_seen, want.smear_done, rsp.smear_done));
      end
    end
  end

  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit first_hold_done = 1'b0;
  bit second_hold_done = 1'b0;

  // Receiver stall pattern; twice it holds off long enough to back up the
  // command side while the sender keeps offering beats.
  always @(negedge clk) begin
    bit s;
    if (!first_hold_done && results_seen >= 60) begin
      first_hold_done = 1'b1;
      hold_left = 400;
    end else if (!second_hold_done && results_seen >= 250) begin
      second_hold_done = 1'b1;
      hold_left = 400;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 4);
      mode_left  = $urandom_range(16, 120);
    end
    mode_left--;
    case (stall_mode)
      0: s = 1'b0;
      1: s = $urandom_range(0, 3) == 0;
      2: s = $urandom_range(0, 1) == 1;
      3: s = $urandom_range(0, 7) != 0;
      default: s = !rsp_stall;
    endcase
    if (hold_left > 0) begin
      hold_left--;
      s = 1'b1;
    end
    rsp_stall <= s;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Two rows of four: a one-pixel gap that is filled, a two-pixel gap that
    // is kept, and a white run at the start of the first row.
    set_region(1, 2, 4, 0);
    queue_write(0, 0, 1'b1);
    queue_write(0, 1, 1'b0);
    queue_write(0, 2, 1'b1);
    queue_write(0, 3, 1'b0);
    queue_write(1, 0, 1'b0);
    queue_write(1, 1, 1'b1);
    queue_write(1, 2, 1'b1);
    queue_write(1, 3, 1'b0);
    queue_write(255, 255, 1'b1);
    queue_write(255, 0, 1'b0);
    queue_write(0, 255, 1'b1);
    queue_read(0, 2);
    queue_smear();
    queue_read(0, 0);
    queue_read(0, 2);
    queue_read(0, 3);
    queue_read(1, 1);
    queue_read(1, 2);
    queue_read(255, 255);
    queue_read(255, 0);
    queue_read(0, 255);
    cmd_backlog.push_back(make_cmd(OP_UNUSED, 255, 255, 1'b1));

    // Empty regions, saturated counts and the threshold extremes.
    run_phase(0, 0, 5, 0);
    run_phase(3, 6, 0, 1);
    run_phase(511, 511, 1, 1);
    run_phase(256, 1, 300, 0);
    run_phase(0, 256, 1, 0);
    run_phase(2, 1, 1, 1);

    while (items_made < ITEM_GOAL)
      run_phase(pick_thr(), pick_count(), pick_count(), $urandom_range(0, 1));

    wait_quiet();
    repeat (30) @(posedge clk);
    if (answers_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", answers_due.size()));
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
